// File: sv/iopr_pkg.sv
// Shared constants, result codes and interface types of the packet reorder unit.
package iopr_pkg;

  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned TAG_W  = 10;
  localparam int unsigned WINDOW = 16;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned CNT_W  = SLOT_W + 1;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD   = LEN_W'(1024);
  localparam logic [SEQ_W-1:0] START_SEQ_RST = SEQ_W'(1);

  localparam logic [1:0] ST_IN_ORDER  = 2'd0;
  localparam logic [1:0] ST_HELD      = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_DROPPED   = 2'd3;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_num;
    logic [LEN_W-1:0] payload_len;
    logic [TAG_W-1:0] payload_tag;
    logic             is_last;
    logic             channel;
  } pkt_in_t;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] seq_out;
    logic [LEN_W-1:0] len_out;
    logic [TAG_W-1:0] tag_out;
    logic             channel_out;
    logic [1:0]       ack_status;
    logic             end_of_run;
    logic             stream_done;
  } res_out_t;

  typedef struct packed {
    logic load;
    logic classify;
    logic scan_step;
    logic emit_ack;
    logic emit_self;
    logic emit_drain;
  } ctl_cmd_t;

  typedef struct packed {
    logic inorder_now;
    logic inorder_q;
    logic scan_done;
    logic run_zero;
    logic run_one;
  } ctl_sts_t;

endpackage

// File: sv/iopr_ctrl.sv
// Sequencing state machine of the packet reorder unit.
module iopr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  iopr_pkg::ctl_sts_t sts_i,
  output iopr_pkg::ctl_cmd_t cmd_o
);
  import iopr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ACK   = 3'd3;
  localparam logic [2:0] S_SELF  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d        = sts_i.inorder_now ? S_SCAN : S_ACK;
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_ACK;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_ACK: begin
        cmd_o.emit_ack = 1'b1;
        state_d        = sts_i.inorder_q ? S_SELF : S_IDLE;
      end
      S_SELF: begin
        cmd_o.emit_self = 1'b1;
        state_d         = sts_i.run_zero ? S_IDLE : S_DRAIN;
      end
      S_DRAIN: begin
        cmd_o.emit_drain = 1'b1;
        state_d          = sts_i.run_one ? S_IDLE : S_DRAIN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/iopr_dp.sv
// Datapath of the packet reorder unit: slot ring, sequence state and result register.
module iopr_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iopr_pkg::pkt_in_t     item_i,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_data_i,
  input  iopr_pkg::ctl_cmd_t    cmd_i,
  output iopr_pkg::ctl_sts_t    sts_o,
  output iopr_pkg::res_out_t    res_o,
  output logic                  res_strobe_o
);
  import iopr_pkg::*;

  pkt_in_t           item_q;
  logic [SEQ_W-1:0]  exp_q;
  logic [SLOT_W-1:0] head_q;
  logic [WINDOW-1:0] valid_q;
  logic [CNT_W-1:0]  count_q;
  logic              last_seen_q;
  logic [1:0]        status_q;
  logic              inorder_q;
  logic [SLOT_W-1:0] run_q;
  logic [SLOT_W-1:0] ptr_q;
  logic              done_q;
  res_out_t          res_q;
  logic              strobe_q;

  logic [LEN_W-1:0] len_mem [WINDOW];
  logic [TAG_W-1:0] tag_mem [WINDOW];

  logic [SEQ_W-1:0]  seq_diff;
  logic [SLOT_W-1:0] slot;
  logic              inorder_c;
  logic              in_window;
  logic              hold_c;
  logic [1:0]        status_c;
  logic              done_c;
  logic [LEN_W-1:0]  len_sat;
  pkt_in_t           item_ld;

  assign len_sat   = (item_i.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : item_i.payload_len;
  assign seq_diff  = item_q.seq_num - exp_q;
  assign slot      = head_q + seq_diff[SLOT_W-1:0];
  assign inorder_c = (seq_diff == '0);
  assign in_window = (seq_diff[SEQ_W-1:SLOT_W] == '0);
  assign hold_c    = !inorder_c && in_window && !valid_q[slot];

  always_comb begin
    item_ld             = item_i;
    item_ld.payload_len = len_sat;
  end

  always_comb begin
    priority if (inorder_c) begin
      status_c = ST_IN_ORDER;
    end else if (seq_diff[SEQ_W-1]) begin
      status_c = ST_DUPLICATE;
    end else if (in_window) begin
      status_c = valid_q[slot] ? ST_DUPLICATE : ST_HELD;
    end else begin
      status_c = ST_DROPPED;
    end
  end

  assign done_c = last_seen_q &&
                  (inorder_q ? (count_q == {1'b0, run_q}) : (count_q == '0));

  assign sts_o.inorder_now = inorder_c;
  assign sts_o.inorder_q   = inorder_q;
  assign sts_o.scan_done   = (count_q == {1'b0, run_q}) || !valid_q[ptr_q];
  assign sts_o.run_zero    = (run_q == '0);
  assign sts_o.run_one     = (run_q == SLOT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= START_SEQ_RST;
      head_q      <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      last_seen_q <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_ack || cmd_i.emit_self || cmd_i.emit_drain;
      if (cfg_we_i) begin
        exp_q       <= cfg_data_i;
        head_q      <= '0;
        valid_q     <= '0;
        count_q     <= '0;
        last_seen_q <= 1'b0;
      end else if (cmd_i.classify) begin
        if (hold_c) begin
          valid_q[slot] <= 1'b1;
          count_q       <= count_q + CNT_W'(1);
        end
        if ((inorder_c || hold_c) && item_q.is_last) begin
          last_seen_q <= 1'b1;
        end
      end else if (cmd_i.emit_self) begin
        exp_q  <= exp_q + SEQ_W'(1);
        head_q <= head_q + SLOT_W'(1);
      end else if (cmd_i.emit_drain) begin
        valid_q[head_q] <= 1'b0;
        count_q         <= count_q - CNT_W'(1);
        exp_q           <= exp_q + SEQ_W'(1);
        head_q          <= head_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_ld;
    end
    if (cmd_i.classify) begin
      status_q  <= status_c;
      inorder_q <= inorder_c;
      run_q     <= '0;
      ptr_q     <= head_q + SLOT_W'(1);
    end
    if (cmd_i.scan_step) begin
      run_q <= run_q + SLOT_W'(1);
      ptr_q <= ptr_q + SLOT_W'(1);
    end
    if (cmd_i.emit_drain) begin
      run_q <= run_q - SLOT_W'(1);
    end
    if (cmd_i.emit_ack) begin
      done_q <= done_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify && hold_c) begin
      len_mem[slot] <= item_q.payload_len;
      tag_mem[slot] <= item_q.payload_tag;
    end
    if (cmd_i.emit_ack) begin
      res_q.kind        <= KIND_ACK;
      res_q.seq_out     <= item_q.seq_num;
      res_q.len_out     <= item_q.payload_len;
      res_q.tag_out     <= item_q.payload_tag;
      res_q.channel_out <= item_q.channel;
      res_q.ack_status  <= status_q;
      res_q.end_of_run  <= !inorder_q;
      res_q.stream_done <= done_c;
    end else if (cmd_i.emit_self) begin
      res_q.kind        <= KIND_DELIVER;
      res_q.seq_out     <= exp_q;
      res_q.len_out     <= item_q.payload_len;
      res_q.tag_out     <= item_q.payload_tag;
      res_q.channel_out <= item_q.channel;
      res_q.ack_status  <= ST_IN_ORDER;
      res_q.end_of_run  <= (run_q == '0);
      res_q.stream_done <= done_q;
    end else if (cmd_i.emit_drain) begin
      res_q.kind        <= KIND_DELIVER;
      res_q.seq_out     <= exp_q;
      res_q.len_out     <= len_mem[head_q];
      res_q.tag_out     <= tag_mem[head_q];
      res_q.channel_out <= item_q.channel;
      res_q.ack_status  <= ST_IN_ORDER;
      res_q.end_of_run  <= (run_q == SLOT_W'(1));
      res_q.stream_done <= done_q;
    end
  end

  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

endmodule

// File: sv/in_order_packet_reorder_unit.sv
// Top level of the in-order packet reorder unit; the receiver cannot stall.
// Duplicate, held and dropped packets pass from start through classify to a single ack word.
// An in-order packet with R held successors first scans the window for its run of R held
// slots, then gives one registered word per cycle for the ack and R + 1 deliveries.
// A new start is taken only in idle, after the ack or after the last in-order delivery.
// Reset is asynchronous, active low, clears the window and expects sequence number 1 first.
module in_order_packet_reorder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  iopr_pkg::pkt_in_t  item_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  output iopr_pkg::res_out_t res_o,
  output logic               res_strobe_o
);
  import iopr_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     cfg_we;

  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  iopr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  iopr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule
